/* rtl/sqlwm_pkg.sv */
package sqlwm_pkg;

  // Item actions carried on the input channel.
  typedef enum logic [1:0] {
    ACT_PATTERN = 2'd0,
    ACT_VALUE   = 2'd1,
    ACT_FINISH  = 2'd2,
    ACT_CLEAR   = 2'd3
  } action_e;

  // Special pattern and value bytes.
  localparam logic [7:0] CH_ANY_RUN = 8'h25;
  localparam logic [7:0] CH_ANY_ONE = 8'h5F;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // Commands from the top level to the pattern store.
  typedef struct packed {
    logic append;
    logic clear;
  } store_cmd_t;

endpackage

/* rtl/sqlwm_closure.sv */
module sqlwm_closure #(
  parameter int Width = 33
) (
  input  logic [Width-1:0] set_i,
  input  logic [Width-1:0] run_i,
  output logic [Width-1:0] closed_o
);

  logic [Width-1:0] gen;
  logic [Width-1:0] sum;
  logic [Width-1:0] carries;

  // A position reached at a run wildcard reaches the next position too, and that
  // chain rides the carry of one add: generate where a set position holds a run
  // wildcard, propagate through further run wildcards.
  assign gen      = run_i & set_i;
  assign sum      = run_i + gen;
  assign carries  = sum ^ run_i ^ gen;
  assign closed_o = set_i | carries;

endmodule

/* rtl/sqlwm_pattern_store.sv */
module sqlwm_pattern_store #(
  parameter int MaxPattern = 32,
  parameter int CntW       = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sqlwm_pkg::store_cmd_t cmd_i,
  input  logic [7:0]            data_byte_i,
  output logic [MaxPattern:0]   run_mask_o,
  output logic [MaxPattern:0]   hit_mask_o,
  output logic [CntW-1:0]       count_o,
  output logic                  overflow_o
);
  import sqlwm_pkg::*;

  localparam int IdxW = (MaxPattern > 1) ? $clog2(MaxPattern) : 1;

  logic [7:0]      pat_q [MaxPattern];
  logic [CntW-1:0] count_q, count_d;
  logic            overflow_q, overflow_d;
  logic            full;

  assign full = (count_q == CntW'(MaxPattern));

  // Count and overflow flag.
  always_comb begin
    count_d    = count_q;
    overflow_d = overflow_q;
    if (cmd_i.clear) begin
      count_d    = '0;
      overflow_d = 1'b0;
    end else if (cmd_i.append) begin
      if (full) begin
        overflow_d = 1'b1;
      end else begin
        count_d = count_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      overflow_q <= 1'b0;
    end else begin
      count_q    <= count_d;
      overflow_q <= overflow_d;
    end
  end

  // Pattern bytes; entries at or above the count are never used.
  always_ff @(posedge clk_i) begin
    if (cmd_i.append && !full) begin
      pat_q[count_q[IdxW-1:0]] <= data_byte_i;
    end
  end

  // Per-position classification against the current byte.
  always_comb begin
    run_mask_o = '0;
    hit_mask_o = '0;
    for (int i = 0; i < MaxPattern; i++) begin
      if (CntW'(i) < count_q) begin
        run_mask_o[i] = (pat_q[i] == CH_ANY_RUN);
        hit_mask_o[i] = (pat_q[i] != CH_ANY_RUN) &&
                        ((pat_q[i] == CH_ANY_ONE) || (pat_q[i] == data_byte_i));
      end
    end
  end

  assign count_o    = count_q;
  assign overflow_o = overflow_q;

endmodule

/* rtl/sql_like_wildcard_matcher_top.sv */
// Channel | Direction | Handshake                | Word
// in      | input     | in_valid_i / in_stall_o  | action_i, data_byte_i, invert_i
// out     | output    | out_valid_o / out_stall_i | matched_o, pattern_overflow_o
//
// Every accepted item waits in the input register until it runs; the position update
// then lands in the state and result registers, and a finish result is offered from
// the result register. One item is accepted per cycle while the input is not stalled;
// the position update is a single add across the pattern positions. Reset clears the
// pattern count, the overflow flag and all valid flags, and sets both position sets to
// the start position. Only a finish meeting a stalled, full result register waits in
// the input register and stalls the input; other actions keep flowing.
module sql_like_wildcard_matcher_top #(
  parameter int MAX_PATTERN = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] action_i,
  input  logic [7:0] data_byte_i,
  input  logic       invert_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       matched_o,
  output logic       pattern_overflow_o
);
  import sqlwm_pkg::*;

  localparam int PosW = MAX_PATTERN + 1;
  localparam int CntW = $clog2(MAX_PATTERN + 1);
  localparam logic [PosW-1:0] PosStart = PosW'(1);

  // Input register.
  logic       s1_valid_q, s1_valid_d;
  logic [1:0] s1_action_q;
  logic [7:0] s1_byte_q;
  logic       s1_invert_q;

  // Position sets.
  logic [PosW-1:0] live_q, live_d;
  logic [PosW-1:0] saved_q, saved_d;

  // Result register.
  logic out_valid_q, out_valid_d;
  logic matched_q, matched_d;
  logic ovf_q, ovf_d;

  logic            in_accept;
  logic            is_finish;
  logic            exec;
  store_cmd_t      store_cmd;
  logic [PosW-1:0] run_mask;
  logic [PosW-1:0] hit_mask;
  logic [CntW-1:0] pat_count;
  logic            pat_overflow;
  logic [PosW-1:0] closure_src;
  logic [PosW-1:0] closed;
  logic [PosW-1:0] next_pos;
  logic            hit;

  // An item in the input register runs unless it is a finish with no room for its result.
  assign is_finish  = (s1_action_q == ACT_FINISH);
  assign exec       = s1_valid_q && (!is_finish || !out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !exec;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign s1_valid_d = in_accept || (s1_valid_q && !exec);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_action_q <= action_i;
      s1_byte_q   <= data_byte_i;
      s1_invert_q <= invert_i;
    end
  end

  // Pattern store commands.
  assign store_cmd.append = exec && (s1_action_q == ACT_PATTERN);
  assign store_cmd.clear  = exec && (s1_action_q == ACT_CLEAR);

  sqlwm_pattern_store #(
    .MaxPattern(MAX_PATTERN),
    .CntW      (CntW)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (store_cmd),
    .data_byte_i(s1_byte_q),
    .run_mask_o (run_mask),
    .hit_mask_o (hit_mask),
    .count_o    (pat_count),
    .overflow_o (pat_overflow)
  );

  // One closure unit serves both the value step and the final judgement.
  assign closure_src = is_finish ? saved_q : live_q;

  sqlwm_closure #(
    .Width(PosW)
  ) u_closure (
    .set_i   (closure_src),
    .run_i   (run_mask),
    .closed_o(closed)
  );

  // Run wildcards keep their position; matching bytes advance by one.
  assign next_pos = (closed & run_mask) | ((closed & hit_mask) << 1);
  assign hit      = closed[pat_count];

  // State and result updates.
  always_comb begin
    live_d      = live_q;
    saved_d     = saved_q;
    matched_d   = matched_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (exec) begin
      unique case (s1_action_q)
        ACT_PATTERN, ACT_CLEAR: begin
          live_d  = PosStart;
          saved_d = PosStart;
        end
        ACT_VALUE: begin
          live_d = next_pos;
          if (s1_byte_q != CH_SPACE) begin
            saved_d = next_pos;
          end
        end
        ACT_FINISH: begin
          live_d      = PosStart;
          saved_d     = PosStart;
          out_valid_d = 1'b1;
          ovf_d       = pat_overflow;
          matched_d   = !pat_overflow && (hit != s1_invert_q);
        end
        default: begin
          live_d = live_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q      <= PosStart;
      saved_q     <= PosStart;
      out_valid_q <= 1'b0;
    end else begin
      live_q      <= live_d;
      saved_q     <= saved_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    matched_q <= matched_d;
    ovf_q     <= ovf_d;
  end

  assign out_valid_o        = out_valid_q;
  assign matched_o          = matched_q;
  assign pattern_overflow_o = ovf_q;

endmodule
